/* sv/wclb_pkg.sv */
// ============================================================================
// wclb_pkg
// Shared types and constants for the wake-up character line buffer.
// ============================================================================
`default_nettype none

package wclb_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 7;
    localparam int unsigned CFG_W      = 64;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CHARS_MAX  = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LO = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_HI = 1'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

endpackage : wclb_pkg

`default_nettype wire

/* sv/wakeup_char_line_buffer.sv */
// ============================================================================
// wakeup_char_line_buffer
// One receive channel: bytes are buffered until a wake-up character arrives,
// then the whole message is replayed one byte per output transfer.
// ============================================================================
//
//  Channel   Direction  Handshake                  Payload
//  rx        in         i_rx_valid / o_rx_ready    i_rx_byte
//  msg       out        o_msg_valid / i_msg_ready  o_msg_byte, o_msg_length, o_is_last
//  cfg       in         i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
//  A received byte is taken in the idle state and written to the message memory.
//  On a wake-up match each buffered byte is read on the single memory port and
//  then loaded into the output register; the read waits while the output
//  register holds a byte that the output side has not yet taken.
//  Reset clears the fill count, the wake-up characters and the output valid;
//  the memory is not cleared, since only bytes of the current message are read.
//  The last byte of a message may wait in the output register while the next
//  received byte is taken.
// ============================================================================
`default_nettype none

module wakeup_char_line_buffer #(
    parameter int unsigned MSG_MAX   = 64,
    parameter int unsigned NUM_MATCH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rx_valid,
    output logic                               o_rx_ready,
    input  wire logic [wclb_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                               o_msg_valid,
    input  wire logic                          i_msg_ready,
    output logic [wclb_pkg::BYTE_W-1:0]        o_msg_byte,
    output logic [wclb_pkg::LEN_W-1:0]         o_msg_length,
    output logic                               o_is_last,
    input  wire logic                          i_cfg_we,
    input  wire logic [wclb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [wclb_pkg::CFG_W-1:0]    i_cfg_data
);

    import wclb_pkg::*;

    localparam int unsigned FILL_W = (MSG_MAX > 1) ? $clog2(MSG_MAX) : 1;

    t_state                  r_state, n_state;
    logic [FILL_W-1:0]       r_fill, n_fill;
    logic [FILL_W-1:0]       r_idx, n_idx;
    logic [FILL_W-1:0]       r_last_idx;
    logic [LEN_W-1:0]        r_len;
    logic [CFG_W-1:0]        r_match_lo, r_match_hi;

    logic [BYTE_W-1:0]       mem [MSG_MAX];
    logic [BYTE_W-1:0]       r_rd_data;

    logic                    r_out_valid;
    logic [BYTE_W-1:0]       r_out_byte;
    logic [LEN_W-1:0]        r_out_len;
    logic                    r_out_last;

    logic [2*CFG_W-1:0]      chars;
    logic                    hit;
    logic                    rx_xfer;
    logic                    out_xfer;
    logic                    rd_en;
    logic                    load;

    assign rx_xfer  = i_rx_valid && o_rx_ready;
    assign out_xfer = r_out_valid && i_msg_ready;

    // Wake-up match against every enabled character.
    assign chars = {r_match_hi, r_match_lo};
    always_comb begin
        hit = 1'b0;
        for (int k = 0; k < NUM_MATCH && k < CHARS_MAX; k++) begin
            if ((chars[BYTE_W*k +: BYTE_W] != '0) &&
                (chars[BYTE_W*k +: BYTE_W] == i_rx_byte)) begin
                hit = 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (rx_xfer && hit) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (!r_out_valid || i_msg_ready) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = (r_idx == r_last_idx) ? S_IDLE : S_READ;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and counters.
    always_comb begin
        o_rx_ready = 1'b0;
        rd_en      = 1'b0;
        load       = 1'b0;
        n_fill     = r_fill;
        n_idx      = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_rx_ready = 1'b1;
                if (rx_xfer) begin
                    if (hit || (r_fill == FILL_W'(MSG_MAX - 1))) begin
                        n_fill = '0;
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_idx = '0;
                end
            end
            S_READ: begin
                rd_en = !r_out_valid || i_msg_ready;
            end
            S_LOAD: begin
                load  = 1'b1;
                n_idx = r_idx + 1'b1;
            end
            default: begin
                o_rx_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_match_lo  <= '0;
            r_match_hi  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MATCH_LO: r_match_lo <= i_cfg_data;
                    CFG_MATCH_HI: r_match_hi <= i_cfg_data;
                    default:      r_match_lo <= r_match_lo;
                endcase
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Message length and last index are latched when the wake character lands.
    always_ff @(posedge i_clk) begin
        if (rx_xfer && hit) begin
            r_last_idx <= r_fill;
            r_len      <= LEN_W'(r_fill) + 1'b1;
        end
        if (load) begin
            r_out_byte <= r_rd_data;
            r_out_len  <= r_len;
            r_out_last <= (r_idx == r_last_idx);
        end
    end

    // Message memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (rx_xfer) begin
            mem[r_fill] <= i_rx_byte;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_idx];
        end
    end

    assign o_msg_valid  = r_out_valid;
    assign o_msg_byte   = r_out_byte;
    assign o_msg_length = r_out_len;
    assign o_is_last    = r_out_last;

endmodule : wakeup_char_line_buffer

`default_nettype wire

/* sv/wclb_checker.sv */
// ============================================================================
// wclb_checker
// Port-level checks on the wake-up character line buffer output channel.
// ============================================================================
`default_nettype none

module wclb_checker #(
    parameter int unsigned MSG_MAX = 64
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_msg_valid,
    input wire logic                        i_msg_ready,
    input wire logic [wclb_pkg::BYTE_W-1:0] o_msg_byte,
    input wire logic [wclb_pkg::LEN_W-1:0]  o_msg_length,
    input wire logic                        o_is_last
);

    import wclb_pkg::*;

    // A pending result is held until its transfer.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_msg_valid && !i_msg_ready) |=> o_msg_valid)
        else $error("o_msg_valid dropped before transfer");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_msg_valid && !i_msg_ready) |=>
            ($stable(o_msg_byte) && $stable(o_msg_length) && $stable(o_is_last)))
        else $error("output payload changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_msg_valid)
        else $error("output valid after reset");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_msg_valid |-> ((o_msg_length != '0) && (o_msg_length <= LEN_W'(MSG_MAX))))
        else $error("message length out of range");

    // Bytes of one message all carry the same length.
    a_len_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_msg_valid && i_msg_ready && !o_is_last) |=>
            (!o_msg_valid || (o_msg_length == $past(o_msg_length))))
        else $error("message length changed inside a message");

endmodule : wclb_checker

bind wakeup_char_line_buffer wclb_checker #(
    .MSG_MAX (MSG_MAX)
) u_wclb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_msg_valid  (o_msg_valid),
    .i_msg_ready  (i_msg_ready),
    .o_msg_byte   (o_msg_byte),
    .o_msg_length (o_msg_length),
    .o_is_last    (o_is_last)
);

`default_nettype wire
